// ===== hw/rtl/iau_pkg.sv =====
// Shared constants, types and arithmetic helpers for the improper angle unit.
// Used by iau_div, iau_sqrt and improper_angle_unit_core; depends on nothing.
package iau_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 40;
    localparam int HORNER_STEPS = 7;
    localparam int FRONT_STAGES = 6;
    localparam int PIPE_LAT = FRONT_STAGES + 3 * SQRT_STEPS + 3 * DIV_STEPS + 1 + 3 + 1
                              + HORNER_STEPS + 3;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] SMALL_Q30   = 31'd1073742;
    localparam logic [29:0] RAD2DEG_Q24 = 30'd961263669;
    localparam logic [23:0] DEG180_Q16  = 24'd11796480;
    localparam logic [63:0] DEG_ROUND   = 64'h20_0000_0000;

    // Horner coefficients of the arc cosine polynomial, Q30, constant term first.
    localparam logic signed [32:0] ACOS_POLY [HORNER_STEPS + 1] = '{
        33'sd1686629690, -33'sd230423709, 33'sd95540460, -33'sd53874249,
        33'sd33169905, -33'sd18348235, 33'sd7161955, -33'sd1355589
    };

    typedef enum logic [1:0] {
        REG_BOX_LEN_X,
        REG_BOX_LEN_Y,
        REG_BOX_LEN_Z,
        REG_PERIODIC_AXES
    } iau_reg_t;

    // One restoring division step: bit 32 is the quotient bit, the rest the remainder.
    function automatic logic [32:0] div_step(input logic [31:0] rem, input logic din,
                                             input logic [31:0] den);
        logic [32:0] t;
        logic [32:0] d;
        t = {rem, din};
        d = t - {1'b0, den};
        if (t >= {1'b0, den})
            div_step = {1'b1, d[31:0]};
        else
            div_step = {1'b0, t[31:0]};
    endfunction

    // One digit of the floor square root: bit 34 is the root bit, the rest the remainder.
    function automatic logic [34:0] sqrt_step(input logic [33:0] rem, input logic [1:0] din,
                                              input logic [31:0] root);
        logic [35:0] t;
        logic [35:0] trial;
        logic [35:0] d;
        t = {rem, din};
        trial = {2'b00, root, 2'b01};
        d = t - trial;
        if (t >= trial)
            sqrt_step = {1'b1, d[33:0]};
        else
            sqrt_step = {1'b0, t[33:0]};
    endfunction

    // Signed Q30 product truncated toward zero; b is a nonnegative magnitude.
    function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
                                                   input logic [30:0] b);
        logic [32:0] ma;
        logic [63:0] pr;
        logic [32:0] q;
        ma = a[32] ? 33'(-a) : 33'(a);
        pr = 64'(ma) * 64'(b);
        q = pr[62:30];
        mul_q30 = a[32] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== hw/rtl/iau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, DIV_STEPS stages.
// Depends on iau_pkg for the step count and the step function.
module iau_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic [63:0]                      num,
    input  logic [31:0]                      den,
    output logic [iau_pkg::DIV_STEPS-1:0]    quo,
    output logic                             ovf
);
    import iau_pkg::*;

    logic [31:0]          rem_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] quo_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] low_reg [DIV_STEPS];
    logic [31:0]          den_reg [DIV_STEPS];
    logic                 ovf_reg [DIV_STEPS];
    logic [32:0]          step_next [DIV_STEPS];
    logic [31:0]          high_bits;

    assign high_bits = 32'(num[63:DIV_STEPS]);

    always_comb
    begin
        step_next[0] = div_step(high_bits, num[DIV_STEPS-1], den);
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            step_next[k] = div_step(rem_reg[k-1], low_reg[k-1][DIV_STEPS-1], den_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= step_next[0][31:0];
            quo_reg[0] <= DIV_STEPS'(step_next[0][32]);
            low_reg[0] <= num[DIV_STEPS-1:0] << 1;
            den_reg[0] <= den;
            // The quotient would not fit in DIV_STEPS bits.
            ovf_reg[0] <= (high_bits >= den);
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                rem_reg[k] <= step_next[k][31:0];
                quo_reg[k] <= {quo_reg[k-1][DIV_STEPS-2:0], step_next[k][32]};
                low_reg[k] <= low_reg[k-1] << 1;
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo = quo_reg[DIV_STEPS-1];
    assign ovf = ovf_reg[DIV_STEPS-1];

endmodule

// ===== hw/rtl/iau_sqrt.sv =====
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// Depends on iau_pkg for the step count and the step function.
module iau_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] arg,
    output logic [31:0] root
);
    import iau_pkg::*;

    logic [33:0] rem_reg  [SQRT_STEPS];
    logic [31:0] root_reg [SQRT_STEPS];
    logic [63:0] arg_reg  [SQRT_STEPS];
    logic [34:0] step_next [SQRT_STEPS];

    always_comb
    begin
        step_next[0] = sqrt_step(34'd0, arg[63:62], 32'd0);
        for (int k = 1; k < SQRT_STEPS; k++)
        begin
            step_next[k] = sqrt_step(rem_reg[k-1], arg_reg[k-1][63:62], root_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= step_next[0][33:0];
            root_reg[0] <= 32'(step_next[0][34]);
            arg_reg[0]  <= arg << 2;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                rem_reg[k]  <= step_next[k][33:0];
                root_reg[k] <= {root_reg[k-1][30:0], step_next[k][34]};
                arg_reg[k]  <= arg_reg[k-1] << 2;
            end
        end
    end

    assign root = root_reg[SQRT_STEPS-1];

endmodule

// ===== hw/rtl/improper_angle_unit_core.sv =====
// Top level of the improper dihedral angle unit: bond vectors, cosines and arc cosine.
// Depends on iau_pkg, iau_sqrt and iau_div.
//
// The unit takes one item of four atom positions per cycle while the output side does
// not stall, and returns one result item per input item, in order. The pipeline depth
// is set by three square roots and three divisions done one bit per stage (32 and 40
// stages each), plus the scaling, dot product, polynomial and degree conversion stages.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall on the output holds every stage.
// Box lengths and the periodic axis mask must be written while no item is in flight.
module improper_angle_unit_core (
    input  logic         clk,
    input  logic         rst_n,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z, 32 bits each
    input  logic [383:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // chi_degrees in bits 23:0, zero above
    output logic [31:0]  m_axis_tdata,
    // degenerate
    output logic         m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    import iau_pkg::*;

    typedef struct packed {
        logic             dgn;
        logic [2:0]       sgn;
        logic [2:0][47:0] mag;
    } iau_sq1_side_t;

    typedef struct packed {
        logic             dgn;
        logic [2:0]       sgn;
        logic [2:0][31:0] lenb;
    } iau_dv1_side_t;

    typedef struct packed {
        logic       dgn;
        logic [2:0] sgn;
    } iau_dv2_side_t;

    typedef struct packed {
        logic               dgn;
        logic signed [32:0] num;
    } iau_sq2_side_t;

    typedef struct packed {
        logic dgn;
        logic sgn;
    } iau_dv3_side_t;

    typedef struct packed {
        logic        dgn;
        logic        neg;
        logic [30:0] x;
    } iau_hn_side_t;

    typedef struct packed {
        logic               dgn;
        logic               neg;
        logic signed [32:0] p;
    } iau_sq3_side_t;

    // Configuration registers.
    logic [31:0] box_len_reg [3];
    logic [2:0]  periodic_reg;

    // Pipeline control.
    logic                en;
    logic [PIPE_LAT-1:0] vld_reg;

    // Front stages.
    logic signed [32:0] dif_reg [3][3];
    logic signed [33:0] raw_reg [3][3];
    logic [32:0]        mag_reg [3][3];
    logic               neg_reg [3][3];
    logic [5:0]         bl_reg  [3];
    logic               dgn3_reg;
    logic signed [23:0] vec_reg [3][3];
    logic               dgn4_reg;
    logic signed [47:0] prod_reg [6][3];
    logic               dgn5_reg;
    logic signed [49:0] dot_reg [6];
    logic               dgn6_reg;

    logic signed [32:0] dif_next [3][3];
    logic signed [33:0] raw_next [3][3];
    logic [32:0]        mag_next [3][3];
    logic [5:0]         bl_next  [3];
    logic               zero_next [3];
    logic signed [23:0] vec_next [3][3];

    // Side lines beside the square root and divider units.
    iau_sq1_side_t sq1_side_reg [SQRT_STEPS];
    iau_dv1_side_t dv1_side_reg [DIV_STEPS];
    iau_dv2_side_t dv2_side_reg [DIV_STEPS];
    iau_sq2_side_t sq2_side_reg [SQRT_STEPS];
    iau_dv3_side_t dv3_side_reg [DIV_STEPS];
    iau_sq3_side_t sq3_side_reg [SQRT_STEPS];
    iau_sq1_side_t sq1_side_next;

    logic [31:0]          len_root [3];
    logic [DIV_STEPS-1:0] dv1_quo  [3];
    logic                 dv1_ovf  [3];
    logic [DIV_STEPS-1:0] dv2_quo  [3];
    logic                 dv2_ovf  [3];
    logic [63:0]          dv1_num  [3];
    logic [31:0]          dv1_den  [3];
    logic [63:0]          dv2_num  [3];
    logic [DIV_STEPS-1:0] q1_sat   [3];

    // Cosine and middle stages.
    logic signed [31:0] cos_reg [3];
    logic               dgn_cs_reg;
    logic signed [31:0] cos_next [3];
    logic [30:0]        m11_reg;
    logic [30:0]        m22_reg;
    logic signed [31:0] m12_reg;
    logic signed [31:0] c0_m1_reg;
    logic               dgn_m1_reg;
    logic [30:0]        s1_reg;
    logic [30:0]        s2_reg;
    logic signed [32:0] num_m2_reg;
    logic               dgn_m2_reg;
    logic [61:0]        sprod_reg;
    logic signed [32:0] num_m3_reg;
    logic               dgn_m3_reg;

    logic [30:0]        c1_mag;
    logic [30:0]        c2_mag;
    logic [61:0]        p11;
    logic [61:0]        p22;
    logic [61:0]        p12;
    logic [30:0]        s1_next;
    logic [30:0]        s2_next;

    logic [31:0]          s12_root;
    logic [31:0]          num_mag;
    logic [DIV_STEPS-1:0] dv3_quo;
    logic                 dv3_ovf;
    logic [30:0]          x_reg;
    logic                 neg_cq_reg;
    logic                 dgn_cq_reg;
    logic [30:0]          x_next;

    logic signed [32:0] hp_reg [HORNER_STEPS];
    iau_hn_side_t       hs_reg [HORNER_STEPS];

    logic [31:0]        om_root;
    logic [30:0]        om_x;
    logic [31:0]        rad_reg;
    logic               neg_r_reg;
    logic               dgn_r_reg;
    logic signed [32:0] rad_next;
    logic [24:0]        deg_reg;
    logic               neg_d_reg;
    logic               dgn_d_reg;
    logic [63:0]        deg_wide;
    logic signed [25:0] fin_next;
    logic [23:0]        chi_reg;
    logic               dgn_out_reg;

    function automatic logic signed [33:0] image_axis(input logic signed [32:0] d,
                                                      input logic [31:0] len,
                                                      input logic on);
        logic [32:0]        mag;
        logic signed [33:0] dx;
        logic signed [33:0] lx;
        dx = 34'(d);
        lx = $signed({2'b00, len});
        mag = d[32] ? 33'(-dx) : 33'(dx);
        if (on && ({mag, 1'b0} > {2'b00, len}))
            image_axis = d[32] ? dx + lx : dx - lx;
        else
            image_axis = dx;
    endfunction

    function automatic logic [5:0] bit_len(input logic [32:0] m);
        logic [5:0] bl;
        bl = 6'd0;
        for (int k = 0; k < 33; k++)
        begin
            if (m[k])
                bl = 6'(k + 1);
        end
        bit_len = bl;
    endfunction

    assign en = !vld_reg[PIPE_LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    // Configuration and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_len_reg[0] <= '0;
            box_len_reg[1] <= '0;
            box_len_reg[2] <= '0;
            periodic_reg   <= '0;
            vld_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (iau_reg_t'(cfg_addr))
                    REG_BOX_LEN_X:     box_len_reg[0] <= cfg_wdata;
                    REG_BOX_LEN_Y:     box_len_reg[1] <= cfg_wdata;
                    REG_BOX_LEN_Z:     box_len_reg[2] <= cfg_wdata;
                    REG_PERIODIC_AXES: periodic_reg   <= cfg_wdata[2:0];
                    default:           periodic_reg   <= periodic_reg;
                endcase
            end
            if (en)
                vld_reg <= {vld_reg[PIPE_LAT-2:0], s_axis_tvalid};
        end
    end

    // Front: bond vectors, imaging, scaling and dot products.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                raw_next[i][j] = image_axis(dif_reg[i][j], box_len_reg[j], periodic_reg[j]);
                mag_next[i][j] = raw_reg[i][j][33] ? 33'(-raw_reg[i][j]) : 33'(raw_reg[i][j]);
            end
        end
        // Bond 1 is a minus b, bond 2 is c minus b, bond 3 is d minus c.
        for (int j = 0; j < 3; j++)
        begin
            dif_next[0][j] = 33'($signed(s_axis_tdata[32*j +: 32]))
                           - 33'($signed(s_axis_tdata[32*(3+j) +: 32]));
            dif_next[1][j] = 33'($signed(s_axis_tdata[32*(6+j) +: 32]))
                           - 33'($signed(s_axis_tdata[32*(3+j) +: 32]));
            dif_next[2][j] = 33'($signed(s_axis_tdata[32*(9+j) +: 32]))
                           - 33'($signed(s_axis_tdata[32*(6+j) +: 32]));
        end
        for (int i = 0; i < 3; i++)
        begin
            bl_next[i] = bit_len(mag_next[i][0] | mag_next[i][1] | mag_next[i][2]);
            zero_next[i] = (bl_next[i] == 6'd0);
        end
        // Shift each vector so that its largest component has exactly 23 bits.
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (bl_reg[i] > 6'd23)
                    vec_next[i][j] = $signed({1'b0, 23'(mag_reg[i][j] >> (bl_reg[i] - 6'd23))});
                else
                    vec_next[i][j] = $signed({1'b0, 23'(mag_reg[i][j] << (6'd23 - bl_reg[i]))});
                if (neg_reg[i][j])
                    vec_next[i][j] = -vec_next[i][j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    dif_reg[i][j] <= dif_next[i][j];
                    raw_reg[i][j] <= raw_next[i][j];
                    mag_reg[i][j] <= mag_next[i][j];
                    neg_reg[i][j] <= raw_reg[i][j][33];
                    vec_reg[i][j] <= vec_next[i][j];
                end
                bl_reg[i] <= bl_next[i];
            end
            dgn3_reg <= zero_next[0] || zero_next[1] || zero_next[2];
            dgn4_reg <= dgn3_reg;
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[0][j] <= vec_reg[0][j] * vec_reg[0][j];
                prod_reg[1][j] <= vec_reg[1][j] * vec_reg[1][j];
                prod_reg[2][j] <= vec_reg[2][j] * vec_reg[2][j];
                prod_reg[3][j] <= vec_reg[0][j] * vec_reg[2][j];
                prod_reg[4][j] <= vec_reg[0][j] * vec_reg[1][j];
                prod_reg[5][j] <= vec_reg[2][j] * vec_reg[1][j];
            end
            dgn5_reg <= dgn4_reg;
            for (int k = 0; k < 6; k++)
            begin
                dot_reg[k] <= 50'(prod_reg[k][0]) + 50'(prod_reg[k][1]) + 50'(prod_reg[k][2]);
            end
            dgn6_reg <= dgn5_reg;
        end
    end

    // Bond lengths.
    always_comb
    begin
        sq1_side_next.dgn = dgn6_reg;
        for (int k = 0; k < 3; k++)
        begin
            sq1_side_next.sgn[k] = dot_reg[3+k][49];
            sq1_side_next.mag[k] = dot_reg[3+k][49] ? 48'(-dot_reg[3+k]) : 48'(dot_reg[3+k]);
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_len
        iau_sqrt u_len (
            .clk  (clk),
            .en   (en),
            .arg  ({16'd0, dot_reg[k][47:0]}),
            .root (len_root[k])
        );
    end

    // Cosines: first division by the length of the first vector of each pair.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dv1_num[k] = 64'({sq1_side_reg[SQRT_STEPS-1].mag[k], 15'd0});
            q1_sat[k]  = dv1_ovf[k] ? '1 : dv1_quo[k];
            dv2_num[k] = 64'({q1_sat[k], 15'd0});
        end
        dv1_den[0] = len_root[0];
        dv1_den[1] = len_root[0];
        dv1_den[2] = len_root[2];
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_cos
        iau_div u_div_a (
            .clk (clk),
            .en  (en),
            .num (dv1_num[k]),
            .den (dv1_den[k]),
            .quo (dv1_quo[k]),
            .ovf (dv1_ovf[k])
        );
        iau_div u_div_b (
            .clk (clk),
            .en  (en),
            .num (dv2_num[k]),
            .den (dv1_side_reg[DIV_STEPS-1].lenb[k]),
            .quo (dv2_quo[k]),
            .ovf (dv2_ovf[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_side_reg[0] <= sq1_side_next;
            for (int k = 1; k < SQRT_STEPS; k++)
                sq1_side_reg[k] <= sq1_side_reg[k-1];
            dv1_side_reg[0].dgn     <= sq1_side_reg[SQRT_STEPS-1].dgn;
            dv1_side_reg[0].sgn     <= sq1_side_reg[SQRT_STEPS-1].sgn;
            dv1_side_reg[0].lenb[0] <= len_root[2];
            dv1_side_reg[0].lenb[1] <= len_root[1];
            dv1_side_reg[0].lenb[2] <= len_root[1];
            for (int k = 1; k < DIV_STEPS; k++)
                dv1_side_reg[k] <= dv1_side_reg[k-1];
            dv2_side_reg[0].dgn <= dv1_side_reg[DIV_STEPS-1].dgn;
            dv2_side_reg[0].sgn <= dv1_side_reg[DIV_STEPS-1].sgn;
            for (int k = 1; k < DIV_STEPS; k++)
                dv2_side_reg[k] <= dv2_side_reg[k-1];
        end
    end

    // Clamp the cosines to one; the third cosine is negated.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (dv2_ovf[k] || (dv2_quo[k] > DIV_STEPS'(Q30_ONE)))
                cos_next[k] = 32'(Q30_ONE);
            else
                cos_next[k] = 32'(dv2_quo[k][30:0]);
            if (dv2_side_reg[DIV_STEPS-1].sgn[k] ^ (k == 2))
                cos_next[k] = -cos_next[k];
        end
        c1_mag = cos_reg[1][31] ? 31'(-cos_reg[1]) : 31'(cos_reg[1]);
        c2_mag = cos_reg[2][31] ? 31'(-cos_reg[2]) : 31'(cos_reg[2]);
        p11 = 62'(c1_mag) * 62'(c1_mag);
        p22 = 62'(c2_mag) * 62'(c2_mag);
        p12 = 62'(c1_mag) * 62'(c2_mag);
        s1_next = Q30_ONE - m11_reg;
        if (s1_next < SMALL_Q30)
            s1_next = SMALL_Q30;
        s2_next = Q30_ONE - m22_reg;
        if (s2_next < SMALL_Q30)
            s2_next = SMALL_Q30;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                cos_reg[k] <= cos_next[k];
            dgn_cs_reg <= dv2_side_reg[DIV_STEPS-1].dgn;
            m11_reg    <= p11[60:30];
            m22_reg    <= p22[60:30];
            m12_reg    <= (cos_reg[1][31] != cos_reg[2][31]) ? -$signed({1'b0, p12[60:30]})
                                                             : $signed({1'b0, p12[60:30]});
            c0_m1_reg  <= cos_reg[0];
            dgn_m1_reg <= dgn_cs_reg;
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            num_m2_reg <= 33'(m12_reg) + 33'(c0_m1_reg);
            dgn_m2_reg <= dgn_m1_reg;
            sprod_reg  <= 62'(s1_reg) * 62'(s2_reg);
            num_m3_reg <= num_m2_reg;
            dgn_m3_reg <= dgn_m2_reg;
        end
    end

    // Normalize by the root of s1*s2.
    iau_sqrt u_s12 (
        .clk  (clk),
        .en   (en),
        .arg  (64'(sprod_reg)),
        .root (s12_root)
    );

    assign num_mag = sq2_side_reg[SQRT_STEPS-1].num[32] ? 32'(-sq2_side_reg[SQRT_STEPS-1].num)
                                                       : 32'(sq2_side_reg[SQRT_STEPS-1].num);

    iau_div u_div_c (
        .clk (clk),
        .en  (en),
        .num (64'({num_mag, 30'd0})),
        .den (s12_root),
        .quo (dv3_quo),
        .ovf (dv3_ovf)
    );

    always_comb
    begin
        if (dv3_ovf || (dv3_quo > DIV_STEPS'(Q30_ONE)))
            x_next = Q30_ONE;
        else
            x_next = dv3_quo[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq2_side_reg[0].dgn <= dgn_m3_reg;
            sq2_side_reg[0].num <= num_m3_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
                sq2_side_reg[k] <= sq2_side_reg[k-1];
            dv3_side_reg[0].dgn <= sq2_side_reg[SQRT_STEPS-1].dgn;
            dv3_side_reg[0].sgn <= sq2_side_reg[SQRT_STEPS-1].num[32];
            for (int k = 1; k < DIV_STEPS; k++)
                dv3_side_reg[k] <= dv3_side_reg[k-1];
            x_reg      <= x_next;
            neg_cq_reg <= dv3_side_reg[DIV_STEPS-1].sgn && (x_next != '0);
            dgn_cq_reg <= dv3_side_reg[DIV_STEPS-1].dgn;
        end
    end

    // Arc cosine polynomial, one Horner step per stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hp_reg[0]     <= ACOS_POLY[HORNER_STEPS-1]
                           + mul_q30(ACOS_POLY[HORNER_STEPS], x_reg);
            hs_reg[0].dgn <= dgn_cq_reg;
            hs_reg[0].neg <= neg_cq_reg;
            hs_reg[0].x   <= x_reg;
            for (int k = 1; k < HORNER_STEPS; k++)
            begin
                hp_reg[k] <= ACOS_POLY[HORNER_STEPS-1-k] + mul_q30(hp_reg[k-1], hs_reg[k-1].x);
                hs_reg[k] <= hs_reg[k-1];
            end
        end
    end

    assign om_x = Q30_ONE - hs_reg[HORNER_STEPS-1].x;

    iau_sqrt u_om (
        .clk  (clk),
        .en   (en),
        .arg  (64'({om_x, 30'd0})),
        .root (om_root)
    );

    // Radians, then degrees in Q16 with rounding half up.
    always_comb
    begin
        rad_next = mul_q30(sq3_side_reg[SQRT_STEPS-1].p, om_root[30:0]);
        if (rad_next[32])
            rad_next = '0;
        deg_wide = 64'(rad_reg) * 64'(RAD2DEG_Q24) + DEG_ROUND;
        if (neg_d_reg)
            fin_next = 26'(DEG180_Q16) - 26'(deg_reg);
        else
            fin_next = 26'(deg_reg);
        if (fin_next[25])
            fin_next = '0;
        else if (fin_next > 26'(DEG180_Q16))
            fin_next = 26'(DEG180_Q16);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq3_side_reg[0].dgn <= hs_reg[HORNER_STEPS-1].dgn;
            sq3_side_reg[0].neg <= hs_reg[HORNER_STEPS-1].neg;
            sq3_side_reg[0].p   <= hp_reg[HORNER_STEPS-1];
            for (int k = 1; k < SQRT_STEPS; k++)
                sq3_side_reg[k] <= sq3_side_reg[k-1];
            rad_reg     <= rad_next[31:0];
            neg_r_reg   <= sq3_side_reg[SQRT_STEPS-1].neg;
            dgn_r_reg   <= sq3_side_reg[SQRT_STEPS-1].dgn;
            deg_reg     <= deg_wide[62:38];
            neg_d_reg   <= neg_r_reg;
            dgn_d_reg   <= dgn_r_reg;
            chi_reg     <= dgn_d_reg ? 24'd0 : fin_next[23:0];
            dgn_out_reg <= dgn_d_reg;
        end
    end

    assign m_axis_tdata  = {8'd0, chi_reg};
    assign m_axis_tuser  = dgn_out_reg;
    assign m_axis_tvalid = vld_reg[PIPE_LAT-1];

endmodule
